/* design/acis_pkg.sv */
package acis_pkg;

  // Opcodes of the supported subset
  localparam logic [7:0] OpBrk    = 8'h00;
  localparam logic [7:0] OpAdcImm = 8'h69;
  localparam logic [7:0] OpLdaImm = 8'hA9;
  localparam logic [7:0] OpStaAbs = 8'h8D;
  localparam logic [7:0] OpTax    = 8'hAA;
  localparam logic [7:0] OpInx    = 8'hE8;

  // Status bit positions
  localparam int FlagN = 7;
  localparam int FlagV = 6;
  localparam int FlagZ = 1;
  localparam int FlagC = 0;
  localparam logic [7:0] FlagMask = 8'hC3;

  // Instruction lengths and original cycle counts
  localparam logic [1:0] LenOne   = 2'd1;
  localparam logic [1:0] LenTwo   = 2'd2;
  localparam logic [1:0] LenThree = 2'd3;
  localparam logic [2:0] CycBrk   = 3'd7;
  localparam logic [2:0] CycSta   = 3'd4;
  localparam logic [2:0] CycBase  = 3'd2;

  localparam logic [15:0] StartAddrReset = 16'h0000;

  // Architectural state
  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  flags;
    logic [15:0] pc;
  } arch_t;

  // One result item
  typedef struct packed {
    logic [7:0]  accumulator_out;
    logic [7:0]  index_x_out;
    logic [7:0]  flags_out;
    logic [15:0] next_pc;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        halted;
    logic [1:0]  length_bytes;
    logic [2:0]  cycle_count;
  } result_t;

  // Replace N and Z from a result byte
  function automatic logic [7:0] with_nz(input logic [7:0] flags, input logic [7:0] value);
    logic [7:0] f;
    f        = flags;
    f[FlagN] = value[7];
    f[FlagZ] = (value == 8'h00);
    return f;
  endfunction

endpackage

/* design/acis_exec.sv */
module acis_exec (
  input  acis_pkg::arch_t   arch,
  input  logic [7:0]        func,
  input  logic [7:0]        operand_low,
  input  logic [7:0]        operand_high,
  output acis_pkg::arch_t   arch_next,
  output acis_pkg::result_t res
);

  logic [8:0] sum;
  logic [7:0] sum_byte;
  logic [7:0] x_inc;
  logic [7:0] adc_flags;
  logic [1:0] pc_step;

  // ADC datapath: binary add with carry-in
  assign sum      = {1'b0, arch.acc} + {1'b0, operand_low} + {8'b0, arch.flags[acis_pkg::FlagC]};
  assign sum_byte = sum[7:0];
  assign x_inc    = arch.x + 8'd1;

  always_comb begin
    adc_flags                  = acis_pkg::with_nz(arch.flags, sum_byte);
    adc_flags[acis_pkg::FlagV] = (arch.acc[7] ^ sum_byte[7]) & (operand_low[7] ^ sum_byte[7]);
    adc_flags[acis_pkg::FlagC] = sum[8];
  end

  // Decode and execute
  always_comb begin
    arch_next         = arch;
    pc_step           = acis_pkg::LenOne;
    res               = '0;
    res.length_bytes  = acis_pkg::LenOne;
    res.cycle_count   = acis_pkg::CycBase;
    unique case (func)
      acis_pkg::OpBrk: begin
        pc_step         = 2'd0;
        res.halted      = 1'b1;
        res.cycle_count = acis_pkg::CycBrk;
      end
      acis_pkg::OpAdcImm: begin
        arch_next.acc    = sum_byte;
        arch_next.flags  = adc_flags;
        pc_step          = acis_pkg::LenTwo;
        res.length_bytes = acis_pkg::LenTwo;
      end
      acis_pkg::OpLdaImm: begin
        arch_next.acc    = operand_low;
        arch_next.flags  = acis_pkg::with_nz(arch.flags, operand_low);
        pc_step          = acis_pkg::LenTwo;
        res.length_bytes = acis_pkg::LenTwo;
      end
      acis_pkg::OpStaAbs: begin
        res.write_enable  = 1'b1;
        res.write_address = {operand_high, operand_low};
        res.write_data    = arch.acc;
        pc_step           = acis_pkg::LenThree;
        res.length_bytes  = acis_pkg::LenThree;
        res.cycle_count   = acis_pkg::CycSta;
      end
      acis_pkg::OpTax: begin
        arch_next.x     = arch.acc;
        arch_next.flags = acis_pkg::with_nz(arch.flags, arch.acc);
      end
      acis_pkg::OpInx: begin
        arch_next.x     = x_inc;
        arch_next.flags = acis_pkg::with_nz(arch.flags, x_inc);
      end
      default: begin
        pc_step = acis_pkg::LenOne;
      end
    endcase
    arch_next.pc        = arch.pc + {14'b0, pc_step};
    res.accumulator_out = arch_next.acc;
    res.index_x_out     = arch_next.x;
    res.flags_out       = arch_next.flags & acis_pkg::FlagMask;
    res.next_pc         = arch_next.pc;
  end

endmodule

/* design/accumulator_cpu_instruction_subset.sv */
// Path: an instruction is captured in the input register at its transfer, then moves
// into the result register once the result slot is free or draining.
// Throughput: one instruction per cycle while the result side does not stall; the 8-bit add
// and flag update in the execute logic between the two registers set the per-item path.
// Reset (rst, synchronous): A, X and status clear to 0, program counter to the
// start_address reset value (0), both stages empty. in_stall rises only while a held result blocks.
module accumulator_cpu_instruction_subset (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // instruction input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  func,
  input  logic [7:0]  operand_low,
  input  logic [7:0]  operand_high,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  accumulator_out,
  output logic [7:0]  index_x_out,
  output logic [7:0]  flags_out,
  output logic [15:0] next_pc,
  output logic        write_enable,
  output logic [15:0] write_address,
  output logic [7:0]  write_data,
  output logic        halted,
  output logic [1:0]  length_bytes,
  output logic [2:0]  cycle_count
);

  logic              in_full;
  logic [7:0]        in_func;
  logic [7:0]        in_lo;
  logic [7:0]        in_hi;
  logic [15:0]       start_address;
  acis_pkg::arch_t   arch;
  acis_pkg::arch_t   arch_next;
  acis_pkg::result_t res_next;
  acis_pkg::result_t res;
  logic              advance;
  logic              in_xfer;

  // Handshake: execute stage moves when the result slot is free or draining
  assign advance   = in_full & (~out_valid | ~out_stall);
  assign in_stall  = in_full & ~advance;
  assign in_xfer   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  acis_exec u_exec (
    .arch         (arch),
    .func         (in_func),
    .operand_low  (in_lo),
    .operand_high (in_hi),
    .arch_next    (arch_next),
    .res          (res_next)
  );

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      start_address <= acis_pkg::StartAddrReset;
      arch          <= '{acc: 8'h00, x: 8'h00, flags: 8'h00, pc: acis_pkg::StartAddrReset};
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_address <= cfg_data;
      end
      if (in_xfer) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        arch      <= arch_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_func <= func;
      in_lo   <= operand_low;
      in_hi   <= operand_high;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign accumulator_out = res.accumulator_out;
  assign index_x_out     = res.index_x_out;
  assign flags_out       = res.flags_out;
  assign next_pc         = res.next_pc;
  assign write_enable    = res.write_enable;
  assign write_address   = res.write_address;
  assign write_data      = res.write_data;
  assign halted          = res.halted;
  assign length_bytes    = res.length_bytes;
  assign cycle_count     = res.cycle_count;

endmodule

/* sim/tb_accumulator_cpu_instruction_subset.sv */
module tb_accumulator_cpu_instruction_subset;

  // Opcodes outside the executed subset, used as one-byte NOPs
  localparam logic [7:0] OpNop       = 8'hEA;
  localparam logic [7:0] OpSpareLow  = 8'h01;
  localparam logic [7:0] OpSpareHigh = 8'hFF;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int          RandomItems = 1750;

  typedef struct packed {
    logic [7:0] op;
    logic [7:0] lo;
    logic [7:0] hi;
  } instr_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  func = '0;
  logic [7:0]  operand_low = '0;
  logic [7:0]  operand_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  accumulator_out;
  logic [7:0]  index_x_out;
  logic [7:0]  flags_out;
  logic [15:0] next_pc;
  logic        write_enable;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic        halted;
  logic [1:0]  length_bytes;
  logic [2:0]  cycle_count;

  accumulator_cpu_instruction_subset dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .operand_low     (operand_low),
    .operand_high    (operand_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .accumulator_out (accumulator_out),
    .index_x_out     (index_x_out),
    .flags_out       (flags_out),
    .next_pc         (next_pc),
    .write_enable    (write_enable),
    .write_address   (write_address),
    .write_data      (write_data),
    .halted          (halted),
    .length_bytes    (length_bytes),
    .cycle_count     (cycle_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Program queue, expected results, architectural shadow state
  instr_t              program_q[$];
  acis_pkg::result_t   retire_q[$];
  logic [7:0]          cpu_acc;
  logic [7:0]          cpu_x;
  logic [7:0]          cpu_flags;
  logic [15:0]         cpu_pc;
  logic [15:0]         start_reg;
  logic                in_fire = 1'b0;
  logic                out_fire = 1'b0;
  int                  feed_wait = 0;
  int                  feed_streak = 0;
  int                  drain_hold = 0;
  int                  drain_streak = 0;
  int                  mismatches = 0;
  int unsigned         tb_cycles = 0;

  // Idle length per transfer; occasional bursts with no idling at all
  function automatic int pause_len(inout int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      streak = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [7:0] nz_update(input logic [7:0] flags, input logic [7:0] value);
    logic [7:0] f;
    f = flags;
    f[acis_pkg::FlagN] = value[7];
    f[acis_pkg::FlagZ] = (value == 8'h00);
    return f;
  endfunction

  // Execute one instruction on the shadow state and build its retire record
  function automatic acis_pkg::result_t execute_instr(input instr_t it);
    acis_pkg::result_t r;
    logic [8:0]        sum;
    r = '0;
    r.length_bytes = acis_pkg::LenOne;
    r.cycle_count = acis_pkg::CycBase;
    case (it.op)
      acis_pkg::OpBrk: begin
        r.halted = 1'b1;
        r.cycle_count = acis_pkg::CycBrk;
      end
      acis_pkg::OpAdcImm: begin
        sum = {1'b0, cpu_acc} + {1'b0, it.lo} + {8'b0, cpu_flags[acis_pkg::FlagC]};
        cpu_flags[acis_pkg::FlagV] = (cpu_acc[7] ^ sum[7]) & (it.lo[7] ^ sum[7]);
        cpu_flags[acis_pkg::FlagC] = sum[8];
        cpu_acc = sum[7:0];
        cpu_flags = nz_update(cpu_flags, cpu_acc);
        r.length_bytes = acis_pkg::LenTwo;
      end
      acis_pkg::OpLdaImm: begin
        cpu_acc = it.lo;
        cpu_flags = nz_update(cpu_flags, cpu_acc);
        r.length_bytes = acis_pkg::LenTwo;
      end
      acis_pkg::OpStaAbs: begin
        r.write_enable = 1'b1;
        r.write_address = {it.hi, it.lo};
        r.write_data = cpu_acc;
        r.length_bytes = acis_pkg::LenThree;
        r.cycle_count = acis_pkg::CycSta;
      end
      acis_pkg::OpTax: begin
        cpu_x = cpu_acc;
        cpu_flags = nz_update(cpu_flags, cpu_x);
      end
      acis_pkg::OpInx: begin
        cpu_x = cpu_x + 8'd1;
        cpu_flags = nz_update(cpu_flags, cpu_x);
      end
      default: ;
    endcase
    // BRK holds the program counter
    if (!r.halted) cpu_pc = cpu_pc + 16'(r.length_bytes);
    r.accumulator_out = cpu_acc;
    r.index_x_out = cpu_x;
    r.flags_out = cpu_flags & acis_pkg::FlagMask;
    r.next_pc = cpu_pc;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Instruction driver
  always @(negedge clk) begin
    instr_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (feed_wait > 0) begin
        feed_wait--;
        in_valid <= 1'b0;
      end else if (program_q.size() > 0) begin
        cur = program_q.pop_front();
        func <= cur.op;
        operand_low <= cur.lo;
        operand_high <= cur.hi;
        in_valid <= 1'b1;
        feed_wait = pause_len(feed_streak);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) drain_hold = pause_len(drain_streak);
      if (drain_hold > 0) begin
        drain_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on instruction transfer, compare on result transfer
  always @(posedge clk) begin : monitor
    acis_pkg::result_t want;
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall)
        retire_q.push_back(execute_instr(instr_t'{func, operand_low, operand_high}));
      if (out_valid && !out_stall) begin
        if (retire_q.size() == 0) begin
          $error("result transfer with no instruction outstanding");
          mismatches++;
        end else begin
          want = retire_q.pop_front();
          check_field("accumulator_out", 16'(want.accumulator_out), 16'(accumulator_out));
          check_field("index_x_out", 16'(want.index_x_out), 16'(index_x_out));
          check_field("flags_out", 16'(want.flags_out), 16'(flags_out));
          check_field("next_pc", want.next_pc, next_pc);
          check_field("write_enable", 16'(want.write_enable), 16'(write_enable));
          check_field("write_address", want.write_address, write_address);
          check_field("write_data", 16'(want.write_data), 16'(write_data));
          check_field("halted", 16'(want.halted), 16'(halted));
          check_field("length_bytes", 16'(want.length_bytes), 16'(length_bytes));
          check_field("cycle_count", 16'(want.cycle_count), 16'(cycle_count));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    tb_cycles++;
    if (tb_cycles > CycleLimit) begin
      $display("FAIL accumulator_cpu_instruction_subset");
      $finish;
    end
  end

  function automatic void queue_instr(input logic [7:0] op, input logic [7:0] lo,
                                      input logic [7:0] hi);
    program_q.push_back(instr_t'{op, lo, hi});
  endfunction

  // Random instruction mix, operands always fully random
  function automatic void queue_random();
    int roll;
    logic [7:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 25) op = acis_pkg::OpAdcImm;
    else if (roll < 40) op = acis_pkg::OpLdaImm;
    else if (roll < 55) op = acis_pkg::OpStaAbs;
    else if (roll < 63) op = acis_pkg::OpTax;
    else if (roll < 75) op = acis_pkg::OpInx;
    else if (roll < 80) op = acis_pkg::OpBrk;
    else op = 8'($urandom_range(0, 255));
    queue_instr(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // Wait for the pipeline to empty, then past its latency
  task automatic settle();
    do @(posedge clk);
    while (program_q.size() != 0 || in_valid || retire_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Start-address write; the design stores the value but never loads it into the program counter
  task automatic write_start(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    start_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    start_reg = acis_pkg::StartAddrReset;
    cpu_acc = '0;
    cpu_x = '0;
    cpu_flags = '0;
    cpu_pc = start_reg;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_start(16'hFFFF);

    // Directed: flag corners, carry-in, stores at both address ends, X wrap
    queue_instr(acis_pkg::OpLdaImm, 8'h00, 8'hFF);
    queue_instr(acis_pkg::OpLdaImm, 8'h80, 8'h00);
    queue_instr(acis_pkg::OpLdaImm, 8'hFF, 8'h5A);
    queue_instr(acis_pkg::OpAdcImm, 8'h01, 8'hFF);
    queue_instr(acis_pkg::OpAdcImm, 8'h00, 8'h00);
    queue_instr(acis_pkg::OpLdaImm, 8'h7F, 8'h00);
    queue_instr(acis_pkg::OpAdcImm, 8'h01, 8'h00);
    queue_instr(acis_pkg::OpLdaImm, 8'h80, 8'h00);
    queue_instr(acis_pkg::OpAdcImm, 8'h80, 8'h00);
    queue_instr(acis_pkg::OpAdcImm, 8'hFF, 8'hA5);
    queue_instr(acis_pkg::OpStaAbs, 8'h00, 8'h00);
    queue_instr(acis_pkg::OpStaAbs, 8'hFF, 8'hFF);
    queue_instr(acis_pkg::OpTax, 8'hFF, 8'hFF);
    queue_instr(acis_pkg::OpInx, 8'h00, 8'h00);
    queue_instr(acis_pkg::OpLdaImm, 8'hFF, 8'h00);
    queue_instr(acis_pkg::OpTax, 8'h00, 8'h00);
    queue_instr(acis_pkg::OpInx, 8'hFF, 8'hFF);
    queue_instr(acis_pkg::OpBrk, 8'hFF, 8'hFF);
    queue_instr(acis_pkg::OpBrk, 8'h00, 8'h00);
    queue_instr(OpNop, 8'h12, 8'h34);
    queue_instr(OpSpareHigh, 8'hFF, 8'hFF);
    queue_instr(OpSpareLow, 8'h00, 8'h00);
    queue_instr(acis_pkg::OpStaAbs, 8'hAA, 8'h55);
    settle();
    write_start(16'h0000);

    // Random mix in two halves with a register write between
    repeat (RandomItems / 2) queue_random();
    settle();
    write_start(16'($urandom_range(0, 65535)));
    repeat (RandomItems / 2) queue_random();
    settle();
    write_start(16'h8000);

    repeat (40) queue_random();
    settle();

    if (mismatches == 0) begin
      $display("PASS accumulator_cpu_instruction_subset");
    end else begin
      $display("FAIL accumulator_cpu_instruction_subset");
    end
    $finish;
  end

endmodule
